### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// Shared clocked assertion forms, all sampled on aclk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and the CRC-16/Modbus byte update for the frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0]  HDR_FIRST  = 8'hAA;
    localparam logic [7:0]  HDR_SECOND = 8'h55;
    localparam logic [7:0]  TAIL_BYTE  = 8'h5D;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [3:0]  FRAME_LEN  = 4'd10;

    // role of a byte inside the frame, set by the front end
    typedef enum logic [3:0] {
        KIND_START,
        KIND_HDR2,
        KIND_TAG,
        KIND_TEMP_HI,
        KIND_TEMP_LO,
        KIND_HUM_HI,
        KIND_HUM_LO,
        KIND_CRC_HI,
        KIND_CRC_LO,
        KIND_TAIL
    } byte_kind_t;

    typedef enum logic [1:0] {
        STATUS_GOOD,
        STATUS_BAD_TAIL,
        STATUS_BAD_CRC
    } frame_status_t;

    // queue entry between front and back end
    typedef struct packed {
        byte_kind_t kind;
        logic [7:0] data;
    } q_entry_t;

    // reflected crc update over one byte, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

### hw/rtl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Header hunt and frame position tracking; tags each useful byte with its role.
// ----------------------------------------------------------------------------
module sfd_front import sfd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    output logic       push_valid,
    input  logic       push_ready,
    output q_entry_t   push_entry
);

    logic [3:0] pos_reg, pos_next;
    logic [3:0] pos_eff;
    logic       take;
    logic       keep;

    assign s_tready = push_ready;
    assign take     = s_tvalid && push_ready;

    // out-of-range positions behave as hunting
    assign pos_eff = (pos_reg >= FRAME_LEN) ? 4'd0 : pos_reg;

    // classify the byte and step the position
    always_comb begin
        pos_next        = pos_reg;
        keep            = 1'b0;
        push_entry.kind = KIND_TAG;
        push_entry.data = s_tdata;
        if (take) begin
            case (pos_eff)
                4'd0: begin
                    if (s_tdata == HDR_FIRST) begin
                        keep            = 1'b1;
                        push_entry.kind = KIND_START;
                        pos_next        = 4'd1;
                    end else begin
                        pos_next = 4'd0;
                    end
                end
                4'd1: begin
                    if (s_tdata == HDR_SECOND) begin
                        keep            = 1'b1;
                        push_entry.kind = KIND_HDR2;
                        pos_next        = 4'd2;
                    end else if (s_tdata == HDR_FIRST) begin
                        // repeated header byte restarts the frame here
                        keep            = 1'b1;
                        push_entry.kind = KIND_START;
                        pos_next        = 4'd1;
                    end else begin
                        pos_next = 4'd0;
                    end
                end
                4'd2: begin
                    keep = 1'b1; push_entry.kind = KIND_TAG;     pos_next = 4'd3;
                end
                4'd3: begin
                    keep = 1'b1; push_entry.kind = KIND_TEMP_HI; pos_next = 4'd4;
                end
                4'd4: begin
                    keep = 1'b1; push_entry.kind = KIND_TEMP_LO; pos_next = 4'd5;
                end
                4'd5: begin
                    keep = 1'b1; push_entry.kind = KIND_HUM_HI;  pos_next = 4'd6;
                end
                4'd6: begin
                    keep = 1'b1; push_entry.kind = KIND_HUM_LO;  pos_next = 4'd7;
                end
                4'd7: begin
                    keep = 1'b1; push_entry.kind = KIND_CRC_HI;  pos_next = 4'd8;
                end
                4'd8: begin
                    keep = 1'b1; push_entry.kind = KIND_CRC_LO;  pos_next = 4'd9;
                end
                default: begin
                    keep = 1'b1; push_entry.kind = KIND_TAIL;    pos_next = 4'd0;
                end
            endcase
        end
    end

    assign push_valid = keep;

    // position register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 4'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

### hw/rtl/sfd_queue.sv
// ----------------------------------------------------------------------------
// sfd_queue
// Small first-in first-out buffer of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sfd_queue import sfd_pkg::*; #(
    parameter int Depth = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_entry,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_entry
);

    localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    q_entry_t        slot_reg [Depth];
    logic [IdxW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IdxW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IdxW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Runs the checksum, holds the frame fields and registers one result per frame.
// ----------------------------------------------------------------------------
module sfd_back import sfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  q_entry_t    pop_entry,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    logic [15:0]        crc_reg, crc_next;
    logic signed [15:0] temp_hold_reg;
    logic [15:0]        hum_hold_reg;
    logic [7:0]         tag_hold_reg;
    logic [7:0]         crc_hi_hold_reg;

    logic               out_valid_reg, out_valid_next;
    frame_status_t      out_status_reg, status_next;
    logic signed [15:0] out_temp_reg;
    logic [15:0]        out_hum_reg;
    logic [7:0]         out_tag_reg;

    logic               out_free;
    logic               do_pop;
    logic               is_tail;

    assign out_free  = !out_valid_reg || m_tready;
    assign is_tail   = (pop_entry.kind == KIND_TAIL);
    assign pop_ready = !is_tail || out_free;
    assign do_pop    = pop_valid && pop_ready;

    // tail byte checked before checksum
    always_comb begin
        if (pop_entry.data != TAIL_BYTE) begin
            status_next = STATUS_BAD_TAIL;
        end else if (crc_reg != 16'h0000) begin
            status_next = STATUS_BAD_CRC;
        end else begin
            status_next = STATUS_GOOD;
        end
    end

    // checksum update per byte role
    always_comb begin
        crc_next = crc_reg;
        if (do_pop) begin
            case (pop_entry.kind)
                KIND_START:   crc_next = crc16_byte(CRC_INIT, pop_entry.data);
                KIND_HDR2,
                KIND_TAG,
                KIND_TEMP_HI,
                KIND_TEMP_LO,
                KIND_HUM_HI,
                KIND_HUM_LO:  crc_next = crc16_byte(crc_reg, pop_entry.data);
                KIND_CRC_HI:  crc_next = crc_reg;
                KIND_CRC_LO:  crc_next = crc_reg ^ {crc_hi_hold_reg, pop_entry.data};
                KIND_TAIL:    crc_next = CRC_INIT;
                default:      crc_next = crc_reg;
            endcase
        end
    end

    // output valid: loaded by tail, cleared when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (do_pop && is_tail) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // field holds
    always_ff @(posedge aclk) begin
        if (do_pop) begin
            case (pop_entry.kind)
                KIND_TAG:     tag_hold_reg        <= pop_entry.data;
                KIND_TEMP_HI: temp_hold_reg[15:8] <= pop_entry.data;
                KIND_TEMP_LO: temp_hold_reg[7:0]  <= pop_entry.data;
                KIND_HUM_HI:  hum_hold_reg[15:8]  <= pop_entry.data;
                KIND_HUM_LO:  hum_hold_reg[7:0]   <= pop_entry.data;
                KIND_CRC_HI:  crc_hi_hold_reg     <= pop_entry.data;
                default:      ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (do_pop && is_tail) begin
            out_status_reg <= status_next;
            out_temp_reg   <= temp_hold_reg;
            out_hum_reg    <= hum_hold_reg;
            out_tag_reg    <= tag_hold_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_tag_reg, out_hum_reg, out_temp_reg, out_status_reg};

endmodule

### hw/rtl/sensor_frame_deframer_crc16.sv
// ----------------------------------------------------------------------------
// sensor_frame_deframer_crc16
// Ten-byte sensor frame receiver with header hunt and CRC-16/Modbus check.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata bits (low to high)                        | per
//  ---------+-----+-------------------------------------------------+-----------
//  s_       | in  | rx_byte[7:0]                                    | one byte
//  m_       | out | frame_status[1:0] temperature_raw[17:2]         | one frame
//           |     | humidity_raw[33:18] frame_tag[41:34] zero[47:42]|
//
//  one byte per cycle while the queue has room; the front end tracks frame
//  position, the back end runs the crc one byte per cycle out of the
//  QueueDepth-entry queue; the result is registered when the back end pops
//  the tail byte; a stalled result holds only tail bytes in the back end;
//  the queue keeps taking bytes until it fills
//  synchronous active-low reset, no clearing pass; hunting starts right after
// ----------------------------------------------------------------------------
module sensor_frame_deframer_crc16 import sfd_pkg::*; #(
    parameter int QueueDepth = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // frame_status, temperature_raw, humidity_raw, frame_tag
);

    logic     push_valid, push_ready;
    q_entry_t push_entry;
    logic     pop_valid, pop_ready;
    q_entry_t pop_entry;

    // classify incoming bytes
    sfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // decoupling queue
    sfd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // checksum and result
    sfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### hw/rtl/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_port_checks
// Port-level checks on the result channel of the frame deframer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // a stalled result stays offered and unchanged
    `SFD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `SFD_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "result changed")

    // status is one of the three defined codes
    `SFD_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[1:0] != 2'b11, "undefined frame status")

    // pad bits above the tag stay zero
    `SFD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[47:42] == 6'b000000, "nonzero pad bits")

endmodule

bind sensor_frame_deframer_crc16 sfd_port_checks u_sfd_port_checks (.*);
